// ----- design/d2i_pkg.sv -----
// Shared types and constants for the double to int64 conversion core.
`default_nettype none
package d2i_pkg;

	localparam int unsigned ExpBits  = 11;
	localparam int unsigned FracBits = 52;
	localparam int unsigned SigBits  = FracBits + 1;
	localparam int unsigned IntBits  = 64;
	localparam int unsigned AmtBits  = 6;

	localparam logic [ExpBits-1:0]  EXP_ALL_ONES   = 11'h7ff;
	localparam logic [ExpBits-1:0]  EXP_UNIT_SHIFT = 11'd1075;	// bias + fraction bits
	localparam logic [ExpBits-1:0]  SHIFT_LIMIT    = 11'd63;
	localparam logic [AmtBits-1:0]  LEFT_FIT_MAX   = 6'd11;		// sig still fits 64 bits
	localparam logic [IntBits-1:0]  HALF_POINT     = 64'h8000_0000_0000_0000;

	typedef enum logic [1:0] {
		MODE_NEAREST = 2'd0,
		MODE_DOWN    = 2'd1,
		MODE_UP      = 2'd2,
		MODE_ZERO    = 2'd3
	} mode_t;

	typedef struct packed {
		logic [IntBits-1:0] operand_bits;
		logic [1:0]         rounding_mode;
	} d2i_in_t;

	typedef struct packed {
		logic [IntBits-1:0] integer_bits;
		logic               invalid_flag;
		logic               overflow_flag;
		logic               inexact_flag;
	} d2i_out_t;

	// decoded operand after the first stage
	typedef struct packed {
		logic               sign;
		mode_t              mode;
		logic               is_nan;
		logic               is_inf;
		logic               is_zero;
		logic               is_tiny;
		logic               left;
		logic               left_big;
		logic [AmtBits-1:0] amt;
		logic [SigBits-1:0] sig;
	} d2i_s1_t;

	// aligned magnitude and rounding info after the second stage
	typedef struct packed {
		logic               sign;
		mode_t              mode;
		logic               inv;
		logic               ovf;
		logic               inx;
		logic               lost;
		logic               half;
		logic               above;
		logic [IntBits-1:0] mag;
	} d2i_s2_t;

	// rounded magnitude after the third stage
	typedef struct packed {
		logic               sign;
		logic               inv;
		logic               ovf;
		logic               inx;
		logic [IntBits-1:0] mag;
	} d2i_s3_t;

endpackage
`default_nettype wire

// ----- design/d2i_stream_if.sv -----
// Valid/ready stream interface carrying one payload beat.
`default_nettype none
interface d2i_stream_if
	import d2i_pkg::*;
#(
	parameter type payload_t = d2i_in_t
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- design/double_to_int64_convert_core.sv -----
// Pipelined IEEE double to 64-bit two's-complement integer converter.
//
//  channel   dir  payload                                        beat
//  operand   in   operand_bits[63:0], rounding_mode[1:0]          valid & ready
//  result    out  integer_bits[63:0], invalid/overflow/inexact    valid & ready
//
// Four register stages: decode, align shift, round add, negate into the output.
// One beat per cycle sustained while the result side is ready; an accepted beat passes
// through the decode, align, round and output registers in turn before its result is valid.
// Each stage takes a new beat when empty or when the next stage advances, so bubbles
// fill during an output stall and nothing is lost or repeated.
// Reset clears the stage valid bits only.
`default_nettype none
module double_to_int64_convert_core
	import d2i_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	d2i_stream_if.sink       operand,
	d2i_stream_if.source     result
);

	logic     vld_s1, vld_s2, vld_s3, vld_s4;
	logic     rdy_s1, rdy_s2, rdy_s3, rdy_in;
	d2i_s1_t  dec, dec_s1;
	d2i_s2_t  aln, aln_s2;
	d2i_s3_t  rnd, rnd_s3;
	d2i_out_t res_s4, res;

	logic               op_sign;
	logic [ExpBits-1:0] op_expo;
	logic [FracBits-1:0] op_frac;
	logic [ExpBits-1:0] lsh, rsh;
	logic               inc;

	assign rdy_s3 = !vld_s4 || result.ready;
	assign rdy_s2 = !vld_s3 || rdy_s3;
	assign rdy_s1 = !vld_s2 || rdy_s2;
	assign rdy_in = !vld_s1 || rdy_s1;
	assign operand.ready = rdy_in;

	// stage 1: decode
	assign op_sign = operand.payload.operand_bits[IntBits-1];
	assign op_expo = operand.payload.operand_bits[IntBits-2:FracBits];
	assign op_frac = operand.payload.operand_bits[FracBits-1:0];
	assign lsh = op_expo - EXP_UNIT_SHIFT;
	assign rsh = EXP_UNIT_SHIFT - op_expo;

	always_comb begin
		dec          = '0;
		dec.sign     = op_sign;
		dec.mode     = mode_t'(operand.payload.rounding_mode);
		dec.sig      = {1'b1, op_frac};
		if (op_expo == EXP_ALL_ONES) begin
			dec.is_nan = (op_frac != '0);
			dec.is_inf = (op_frac == '0);
		end else if (op_expo == '0) begin
			dec.is_zero = (op_frac == '0);
			dec.is_tiny = (op_frac != '0);
		end else if (op_expo >= EXP_UNIT_SHIFT) begin
			dec.left     = 1'b1;
			dec.left_big = (lsh >= SHIFT_LIMIT);
			dec.amt      = lsh[AmtBits-1:0];
		end else begin
			dec.is_tiny = (rsh >= SHIFT_LIMIT);
			dec.amt     = rsh[AmtBits-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_in) begin
			vld_s1 <= operand.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_in && operand.valid) begin
			dec_s1 <= dec;
		end
	end

	// stage 2: align
	d2i_align u_align (
		.dec (dec_s1),
		.aln (aln)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && vld_s1) begin
			aln_s2 <= aln;
		end
	end

	// stage 3: round
	always_comb begin
		inc = 1'b0;
		if (aln_s2.lost) begin
			case (aln_s2.mode)
				MODE_NEAREST: inc = aln_s2.above || (aln_s2.half && aln_s2.mag[0]);
				MODE_DOWN:    inc = aln_s2.sign;
				MODE_UP:      inc = !aln_s2.sign;
				default:      inc = 1'b0;
			endcase
		end
		rnd      = '0;
		rnd.sign = aln_s2.sign;
		rnd.inv  = aln_s2.inv;
		rnd.ovf  = aln_s2.ovf;
		rnd.inx  = aln_s2.inx || aln_s2.lost;
		rnd.mag  = aln_s2.mag + {{(IntBits-1){1'b0}}, inc};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (rdy_s2) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s2) begin
			rnd_s3 <= rnd;
		end
	end

	// stage 4: apply sign into the output register
	always_comb begin
		res.integer_bits  = rnd_s3.sign ? (IntBits'(0) - rnd_s3.mag) : rnd_s3.mag;
		res.invalid_flag  = rnd_s3.inv;
		res.overflow_flag = rnd_s3.ovf;
		res.inexact_flag  = rnd_s3.inx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (rdy_s3) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && vld_s3) begin
			res_s4 <= res;
		end
	end

	assign result.valid   = vld_s4;
	assign result.payload = res_s4;

`ifndef SYNTHESIS
	a_invalid_clean: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && res_s4.invalid_flag |->
			!res_s4.overflow_flag && !res_s4.inexact_flag && (res_s4.integer_bits == '0))
		else $error("NaN result carries extra flags or nonzero value");

	a_overflow_inexact: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && res_s4.overflow_flag |-> res_s4.inexact_flag)
		else $error("overflow without inexact");

	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && !rdy_s3 |=> vld_s3 && $stable(rnd_s3))
		else $error("stage 3 beat changed while stalled");

	a_s2_lost_round: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && aln_s2.lost |-> !aln_s2.ovf && !aln_s2.inv)
		else $error("discarded bits on an overflow or NaN beat");
`endif

endmodule
`default_nettype wire

// ----- design/d2i_align.sv -----
// Alignment shifter: places the significand at integer weight and extracts round bits.
`default_nettype none
module d2i_align
	import d2i_pkg::*;
(
	input  d2i_s1_t dec,
	output d2i_s2_t aln
);

	logic [IntBits-1:0]   left_mag;
	logic [2*IntBits-1:0] right_wide;
	logic [IntBits-1:0]   rest;

	assign left_mag   = {{(IntBits-SigBits){1'b0}}, dec.sig} << dec.amt;
	assign right_wide = {{(IntBits-SigBits){1'b0}}, dec.sig, {IntBits{1'b0}}} >> dec.amt;

	always_comb begin
		aln      = '0;
		aln.sign = dec.sign;
		aln.mode = dec.mode;
		rest     = '0;
		if (dec.is_nan) begin
			aln.inv = 1'b1;
		end else if (dec.is_inf) begin
			aln.ovf = 1'b1;
			aln.inx = 1'b1;
		end else if (dec.is_zero) begin
			aln.mag = '0;
		end else if (dec.is_tiny) begin
			// only a sticky bit remains, below half
			rest = {{(IntBits-1){1'b0}}, 1'b1};
		end else if (dec.left) begin
			if (dec.left_big) begin
				aln.ovf = 1'b1;
				aln.inx = 1'b1;
			end else begin
				aln.mag = left_mag;
				// the leading one leaves the word once the shift passes the fit limit
				aln.ovf = (dec.amt > LEFT_FIT_MAX);
				aln.inx = (dec.amt > LEFT_FIT_MAX);
			end
		end else begin
			aln.mag = right_wide[2*IntBits-1:IntBits];
			rest    = right_wide[IntBits-1:0];
		end
		aln.lost  = (rest != '0);
		aln.half  = (rest == HALF_POINT);
		aln.above = rest[IntBits-1] && (rest[IntBits-2:0] != '0);
	end

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for the pipelined double to int64 conversion core.
`timescale 1ns / 1ps
module tb
	import d2i_pkg::*;
();

	localparam int RandomItems   = 400;
	localparam int DirectedItems = 26;

	// flag triples in result order: invalid, overflow, inexact
	localparam logic [2:0] NO_FLAGS = 3'b000;
	localparam logic [2:0] INV      = 3'b100;
	localparam logic [2:0] OVF_INX  = 3'b011;
	localparam logic [2:0] INX      = 3'b001;

	typedef struct {
		logic [63:0] operand_bits;
		mode_t       mode;
		bit          fixed;
		d2i_out_t    result;
	} vector_t;

	// fixed rows carry their result; the rest go through the predictor
	vector_t directed_vectors [0:DirectedItems-1] = '{
		'{64'h0000_0000_0000_0000, MODE_NEAREST, 1, {64'h0, NO_FLAGS}},
		'{64'h8000_0000_0000_0000, MODE_ZERO,    1, {64'h0, NO_FLAGS}},
		'{64'h7ff8_0000_0000_0000, MODE_NEAREST, 1, {64'h0, INV}},
		'{64'hffff_ffff_ffff_ffff, MODE_UP,      1, {64'h0, INV}},
		'{64'h7ff0_0000_0000_0000, MODE_DOWN,    1, {64'h0, OVF_INX}},
		'{64'hfff0_0000_0000_0000, MODE_UP,      1, {64'h0, OVF_INX}},
		'{64'h0000_0000_0000_0001, MODE_UP,      1, {64'h1, INX}},
		'{64'h800f_ffff_ffff_ffff, MODE_DOWN,    1, {64'hffff_ffff_ffff_ffff, INX}},
		'{64'h000f_ffff_ffff_ffff, MODE_NEAREST, 1, {64'h0, INX}},
		'{64'h3ff0_0000_0000_0000, MODE_NEAREST, 1, {64'h1, NO_FLAGS}},
		'{64'hbff0_0000_0000_0000, MODE_ZERO,    1, {64'hffff_ffff_ffff_ffff, NO_FLAGS}},
		'{64'h3fe0_0000_0000_0000, MODE_NEAREST, 1, {64'h0, INX}},
		'{64'h3ff8_0000_0000_0000, MODE_NEAREST, 1, {64'h2, INX}},
		'{64'h4004_0000_0000_0000, MODE_NEAREST, 1, {64'h2, INX}},
		'{64'hc004_0000_0000_0000, MODE_DOWN,    0, '0},
		'{64'h3fe8_0000_0000_0000, MODE_NEAREST, 0, '0},
		'{64'h3ff0_0000_0000_0001, MODE_ZERO,    0, '0},
		'{64'hbff0_0000_0000_0001, MODE_UP,      0, '0},
		'{64'h43e0_0000_0000_0000, MODE_NEAREST, 1, {64'h8000_0000_0000_0000, NO_FLAGS}},
		'{64'h43ef_ffff_ffff_ffff, MODE_ZERO,    1, {64'hffff_ffff_ffff_f800, NO_FLAGS}},
		'{64'h43f0_0000_0000_0000, MODE_NEAREST, 1, {64'h0, OVF_INX}},
		'{64'h4400_0000_0000_0001, MODE_UP,      0, '0},
		'{64'h4710_0000_0000_0000, MODE_DOWN,    0, '0},
		'{64'hffef_ffff_ffff_ffff, MODE_UP,      1, {64'h0, OVF_INX}},
		'{64'h0010_0000_0000_0000, MODE_UP,      0, '0},
		'{64'h3f5f_ffff_ffff_ffff, MODE_NEAREST, 0, '0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	d2i_stream_if #(.payload_t(d2i_in_t))  operand_bus ();
	d2i_stream_if #(.payload_t(d2i_out_t)) result_bus ();

	double_to_int64_convert_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.operand(operand_bus),
		.result(result_bus)
	);

	d2i_out_t expected_results[$];
	int n_errors, n_checked, n_invalid, n_overflow, n_inexact;
	bit no_idle;

	always #6 clk = ~clk;

	function automatic d2i_out_t convert_double(logic [63:0] bits, mode_t mode);
		logic        sign;
		logic [10:0] expo;
		logic [63:0] sig, mag, rest;
		int          shift;
		bit          lost;
		d2i_out_t    r;
		sign = bits[63];
		expo = bits[62:52];
		sig  = {11'd0, 1'b1, bits[51:0]};
		mag  = '0;
		rest = '0;
		lost = 1'b0;
		r    = '0;
		if (expo == EXP_ALL_ONES) begin
			if (bits[51:0] != 0) begin
				r.invalid_flag = 1'b1;
			end else begin
				r.overflow_flag = 1'b1;
				r.inexact_flag  = 1'b1;
			end
		end else if (bits[62:0] != 0) begin
			shift = int'(expo) - int'(EXP_UNIT_SHIFT);
			if (expo == 0) begin
				// denormal: only a sticky bit survives
				rest = 64'd1;
				lost = 1'b1;
			end else if (shift >= 0) begin
				r.overflow_flag = 1'b1;
				r.inexact_flag  = 1'b1;
				if (shift < 63) begin
					mag = sig << shift;
					if ((mag >> shift) == sig) begin
						r.overflow_flag = 1'b0;
						r.inexact_flag  = 1'b0;
					end
				end
			end else begin
				if (-shift < 63) begin
					mag  = sig >> (-shift);
					rest = sig << (64 + shift);
				end else begin
					rest = 64'd1;
				end
				lost = (rest != 0);
			end
			if (lost) begin
				r.inexact_flag = 1'b1;
				case (mode)
				MODE_NEAREST: begin
					if (rest == HALF_POINT)
						mag += {63'd0, mag[0]};
					else if (rest > HALF_POINT)
						mag += 64'd1;
				end
				MODE_DOWN: begin
					mag += {63'd0, sign};
				end
				MODE_UP: begin
					mag += {63'd0, !sign};
				end
				default: begin
				end
				endcase
			end
			if (sign)
				mag = -mag;
		end
		r.integer_bits = mag;
		return r;
	endfunction

	// bias exponents toward the region where rounding and overflow happen
	function automatic logic [63:0] random_double();
		logic [63:0] raw;
		logic [10:0] expo;
		logic [51:0] frac;
		int          pick;
		raw  = {$urandom, $urandom};
		frac = raw[51:0];
		pick = $urandom_range(0, 99);
		if (pick < 10)
			expo = '0;
		else if (pick < 16)
			expo = EXP_ALL_ONES;
		else if (pick < 76)
			expo = 11'($urandom_range(1000, 1150));
		else
			expo = raw[62:52];
		case ($urandom_range(0, 3))
		1: begin
			// trailing zeros make exact halves and exact integers common
			frac &= {52{1'b1}} << $urandom_range(0, 52);
		end
		2: begin
			frac = '0;
		end
		default: begin
		end
		endcase
		return {1'($urandom), expo, frac};
	endfunction

	task automatic send_operand(logic [63:0] bits, mode_t mode, d2i_out_t want);
		int      gap;
		bit      taken;
		d2i_in_t beat;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		beat.operand_bits  = bits;
		beat.rounding_mode = mode;
		if (gap > 0) begin
			operand_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		operand_bus.valid   <= 1'b1;
		operand_bus.payload <= beat;
		do begin
			// handshake signals settle after the rising edge; sample mid-cycle
			@(negedge clk);
			taken = operand_bus.valid && operand_bus.ready;
			if (taken)
				expected_results.push_back(want);
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic report_field(string field, logic [63:0] want, logic [63:0] got);
		$display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
		n_errors++;
	endtask

	always @(negedge clk) begin
		d2i_out_t want, got;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			got = result_bus.payload;
			if (expected_results.size() == 0) begin
				$display("%0t: result beat with nothing expected: actual %h", $time, got);
				n_errors++;
			end else begin
				want = expected_results.pop_front();
				n_checked++;
				n_invalid  += int'(want.invalid_flag);
				n_overflow += int'(want.overflow_flag);
				n_inexact  += int'(want.inexact_flag);
				if (got.integer_bits !== want.integer_bits)
					report_field("integer_bits", want.integer_bits, got.integer_bits);
				if (got.invalid_flag !== want.invalid_flag)
					report_field("invalid_flag", 64'(want.invalid_flag),
						64'(got.invalid_flag));
				if (got.overflow_flag !== want.overflow_flag)
					report_field("overflow_flag", 64'(want.overflow_flag),
						64'(got.overflow_flag));
				if (got.inexact_flag !== want.inexact_flag)
					report_field("inexact_flag", 64'(want.inexact_flag),
						64'(got.inexact_flag));
			end
		end
	end

	initial begin
		int  stall;
		bit  taken;
		result_bus.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				result_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_bus.ready <= 1'b1;
			do begin
				@(negedge clk);
				taken = result_bus.valid && result_bus.ready;
				@(posedge clk);
			end while (!taken);
		end
	end

	initial begin
		logic [63:0] bits;
		mode_t       mode;
		operand_bus.valid   <= 1'b0;
		operand_bus.payload <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_vectors[i]) begin
			send_operand(directed_vectors[i].operand_bits, directed_vectors[i].mode,
				directed_vectors[i].fixed ? directed_vectors[i].result :
				convert_double(directed_vectors[i].operand_bits, directed_vectors[i].mode));
		end
		for (int i = 0; i < RandomItems; i++) begin
			// hold both sides busy through one stretch to run at full rate
			no_idle = (i >= 150 && i < 230);
			bits = random_double();
			mode = mode_t'($urandom_range(0, 3));
			send_operand(bits, mode, convert_double(bits, mode));
		end
		operand_bus.valid <= 1'b0;
		no_idle = 1'b0;
		wait (expected_results.size() == 0);
		repeat (8) @(posedge clk);
		$display("Checked %0d results: %0d directed and %0d random operands, all rounding modes.",
			n_checked, DirectedItems, RandomItems);
		$display("Expected flags seen: %0d invalid, %0d overflow, %0d inexact; %0d mismatches.",
			n_invalid, n_overflow, n_inexact, n_errors);
		if (n_errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timeout with %0d results still expected.", expected_results.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
